// ===== rtl/ascs_pkg.sv =====
// shared types and constants for the annex-b start code splitter
package ascs_pkg;

	localparam int LINE_DEPTH  = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int LCNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [7:0] ONE_BYTE  = 8'h01;
	localparam logic [4:0] TYPE_MASK = 5'h1F;
	localparam logic [1:0] ZRUN_MAX  = 2'd2;

	// one result byte as it waits in the queue
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [4:0] ntype;
	} ascs_rec_t;

	// up to two results produced by one input byte
	typedef struct packed {
		logic [1:0] num;
		ascs_rec_t  rec0;
		ascs_rec_t  rec1;
	} ascs_push_t;

endpackage

// ===== rtl/ascs_front.sv =====
// front part: start code search, pending line and result classification
module ascs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        stream_byte,
	output ascs_pkg::ascs_push_t push
);
	import ascs_pkg::*;

	logic              unit_open_q;
	logic              guard_q;
	logic              first_q;
	logic [1:0]        zrun_q;
	logic [LCNT_W-1:0] lcnt_q;
	logic [4:0]        ntype_q;
	logic [7:0]        line_q [LINE_DEPTH];

	logic              unit_open_d;
	logic              guard_d;
	logic              first_d;
	logic [1:0]        zrun_d;
	logic [LCNT_W-1:0] lcnt_d;
	logic [4:0]        ntype_d;
	logic [7:0]        line_d [LINE_DEPTH];

	logic              start_hit;
	logic [1:0]        zrun_cnt;
	logic [1:0]        keep_raw;
	logic [1:0]        keep;

	assign start_hit = (stream_byte == ONE_BYTE) && (zrun_q >= ZRUN_MAX);

	// saturating zero run counter
	always_comb begin
		if (stream_byte == ZERO_BYTE) begin
			zrun_cnt = (zrun_q < ZRUN_MAX) ? zrun_q + 2'd1 : zrun_q;
		end else begin
			zrun_cnt = 2'd0;
		end
	end

	// bytes kept at a close: drop the start code zeros and a zero ahead of them, if any
	always_comb begin
		keep_raw = (lcnt_q >= LCNT_W'(2)) ? 2'(lcnt_q - LCNT_W'(2)) : 2'd0;
		keep = keep_raw;
		if (keep_raw == 2'd1 && line_q[0] == ZERO_BYTE) begin
			keep = 2'd0;
		end else if (keep_raw == 2'd2 && line_q[1] == ZERO_BYTE) begin
			keep = 2'd1;
		end
	end

	// next state and results of one transfer
	always_comb begin
		unit_open_d = unit_open_q;
		guard_d     = guard_q;
		first_d     = first_q;
		zrun_d      = zrun_q;
		lcnt_d      = lcnt_q;
		ntype_d     = ntype_q;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_d[i] = line_q[i];
		end
		push.num        = 2'd0;
		push.rec0.data  = line_q[0];
		push.rec0.first = first_q;
		push.rec0.last  = 1'b0;
		push.rec0.ntype = ntype_q;
		push.rec1.data  = line_q[1];
		push.rec1.first = 1'b0;
		push.rec1.last  = 1'b1;
		push.rec1.ntype = ntype_q;

		if (fire) begin
			if (!unit_open_q) begin
				// hunting for the first start code
				if (start_hit) begin
					unit_open_d = 1'b1;
					guard_d     = 1'b1;
					zrun_d      = 2'd0;
					lcnt_d      = '0;
					first_d     = 1'b1;
				end else begin
					zrun_d = zrun_cnt;
				end
			end else if (guard_q) begin
				// first payload byte sets the unit type
				line_d[0] = stream_byte;
				lcnt_d    = LCNT_W'(1);
				ntype_d   = stream_byte[4:0] & TYPE_MASK;
				guard_d   = 1'b0;
				zrun_d    = 2'd0;
			end else if (start_hit) begin
				// close the unit, flush the kept bytes, open the next one
				push.num       = keep;
				push.rec0.last = (keep == 2'd1);
				unit_open_d    = 1'b1;
				guard_d        = 1'b1;
				zrun_d         = 2'd0;
				lcnt_d         = '0;
				first_d        = 1'b1;
			end else begin
				zrun_d = zrun_cnt;
				if (lcnt_q >= LCNT_W'(LINE_DEPTH)) begin
					// line full: oldest byte leaves
					push.num = 2'd1;
					first_d  = 1'b0;
					for (int i = 0; i < LINE_DEPTH - 1; i++) begin
						line_d[i] = line_q[i + 1];
					end
					line_d[LINE_DEPTH - 1] = stream_byte;
				end else begin
					line_d[lcnt_q[LCNT_W-2:0]] = stream_byte;
					lcnt_d = lcnt_q + LCNT_W'(1);
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_open_q <= 1'b0;
			guard_q     <= 1'b0;
			first_q     <= 1'b1;
			zrun_q      <= 2'd0;
			lcnt_q      <= '0;
			ntype_q     <= '0;
		end else begin
			unit_open_q <= unit_open_d;
			guard_q     <= guard_d;
			first_q     <= first_d;
			zrun_q      <= zrun_d;
			lcnt_q      <= lcnt_d;
			ntype_q     <= ntype_d;
		end
	end

	// pending line payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_q[i] <= line_d[i];
		end
	end

endmodule

// ===== rtl/ascs_queue.sv =====
// back part: result queue taking up to two entries a cycle, handing out one
module ascs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ascs_pkg::ascs_push_t push,
	output logic                 has_room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ascs_pkg::ascs_rec_t  head
);
	import ascs_pkg::*;

	ascs_rec_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QPTR_W-1:0] wr_ptr_nx;

	assign has_room  = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.rec0;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_nx] <= push.rec1;
		end
	end

endmodule

// ===== rtl/annexb_start_code_splitter.sv =====
// top level of the annex-b start code splitter
// Takes one stream byte per transfer and emits NAL unit payload bytes with the
// start codes removed, flagged first/last and tagged with the unit type. An
// input byte is taken every cycle while the four-entry result queue holds at
// most two entries; the output side drains one byte per cycle while out_ready
// is high, so with a ready receiver the sustained rate is one byte per clock.
// A payload byte leaves the classifier when the fourth byte after it
// arrives (four-byte pending line) or when the next start code closes the unit;
// the closing start code can release two bytes in one cycle. Bytes before the
// first 00 00 01 are dropped; the unfinished last unit never gets its last flag.
module annexb_start_code_splitter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] stream_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       unit_first,
	output logic       unit_last,
	output logic [4:0] unit_type
);
	import ascs_pkg::*;

	ascs_push_t push;
	ascs_rec_t  head;
	logic       has_room;
	logic       fire;

	assign in_ready = has_room;
	assign fire     = in_valid && has_room;

	// classifier and pending line
	ascs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.stream_byte (stream_byte),
		.push        (push)
	);

	// result queue and output side
	ascs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.has_room  (has_room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign payload_byte = head.data;
	assign unit_first   = head.first;
	assign unit_last    = head.last;
	assign unit_type    = head.ntype;

endmodule

// ===== verif/annexb_start_code_splitter_tb.sv =====
// testbench for the annex-b start code splitter: directed and random byte streams
import ascs_pkg::*;

// predicts the payload bytes of the splitter and checks the ones it delivers
class splitter_scoreboard;
	bit                  in_unit;
	bit                  at_header;
	bit                  first_due;
	logic [1:0]          zero_run;
	logic [4:0]          nal_type;
	logic [7:0]          line_bytes [LINE_DEPTH];
	int unsigned         line_count;
	ascs_rec_t           expected_bytes [$];
	int unsigned         errors;
	int unsigned         checked;

	function new();
		in_unit    = 1'b0;
		at_header  = 1'b0;
		first_due  = 1'b1;
		zero_run   = '0;
		nal_type   = '0;
		line_count = 0;
		errors     = 0;
		checked    = 0;
	endfunction

	// a start code was found: a fresh unit begins with its header byte
	function void start_unit();
		in_unit    = 1'b1;
		at_header  = 1'b1;
		zero_run   = '0;
		line_count = 0;
		first_due  = 1'b1;
	endfunction

	// saturating count of searchable zero bytes
	function void track_zero(logic [7:0] b);
		if (b == ZERO_BYTE) begin
			if (zero_run < ZRUN_MAX)
				zero_run++;
		end else begin
			zero_run = '0;
		end
	endfunction

	function void queue_byte(logic [7:0] b, bit last);
		ascs_rec_t rec;
		rec.data  = b;
		rec.first = first_due;
		rec.last  = last;
		rec.ntype = nal_type;
		expected_bytes.push_back(rec);
		first_due = 1'b0;
	endfunction

	// advance the predicted parser by one accepted stream byte
	function void note_stream_byte(logic [7:0] b);
		int keep;
		// hunting for the first start code
		if (!in_unit) begin
			if (b == ONE_BYTE && zero_run >= ZRUN_MAX)
				start_unit();
			else
				track_zero(b);
			return;
		end
		// header byte: never part of a start code
		if (at_header) begin
			line_bytes[0] = b;
			line_count    = 1;
			nal_type      = b[4:0] & TYPE_MASK;
			at_header     = 1'b0;
			zero_run      = '0;
			return;
		end
		// start code closes the unit, dropping its zeros and a zero ahead of them, if any
		if (b == ONE_BYTE && zero_run >= ZRUN_MAX) begin
			keep = (line_count >= 2) ? int'(line_count) - 2 : 0;
			if (keep >= 1 && line_bytes[keep - 1] == ZERO_BYTE)
				keep--;
			for (int i = 0; i < keep; i++)
				queue_byte(line_bytes[i], i == keep - 1);
			start_unit();
			return;
		end
		// ordinary unit byte: the oldest one leaves once the line is full
		track_zero(b);
		if (line_count >= LINE_DEPTH) begin
			queue_byte(line_bytes[0], 1'b0);
			for (int i = 0; i < LINE_DEPTH - 1; i++)
				line_bytes[i] = line_bytes[i + 1];
			line_count = LINE_DEPTH - 1;
		end
		line_bytes[line_count] = b;
		line_count++;
	endfunction

	task report_mismatch(string what);
		if (errors < 50)
			$display("mismatch at payload byte %0d: %s", checked, what);
		errors++;
	endtask

	// compare one delivered payload byte with the oldest prediction
	task check_payload_byte(logic [7:0] data, logic first, logic last, logic [4:0] ntype);
		ascs_rec_t want;
		checked++;
		if (expected_bytes.size() == 0) begin
			report_mismatch($sformatf("byte %02h delivered with none predicted", data));
			return;
		end
		want = expected_bytes.pop_front();
		if (data !== want.data)
			report_mismatch($sformatf("payload_byte %02h, want %02h", data, want.data));
		if (first !== want.first)
			report_mismatch($sformatf("unit_first %0b, want %0b", first, want.first));
		if (last !== want.last)
			report_mismatch($sformatf("unit_last %0b, want %0b", last, want.last));
		if (ntype !== want.ntype)
			report_mismatch($sformatf("unit_type %0d, want %0d", ntype, want.ntype));
	endtask
endclass

module annexb_start_code_splitter_tb;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int HOLD_CYCLES    = 120;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int OPENING_LEN    = 24;

	// hunting with a false 00 01, a 4-byte start code, a zero header with a
	// non-start 00 01 after it, a long zero run, a one-byte unit of type 31
	// and a unit that trims down to nothing
	localparam logic [7:0] OPENING [OPENING_LEN] = '{
		8'hFF, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
		8'hFF, 8'h00, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h00, 8'h01
	};

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] stream_byte = '0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] payload_byte;
	logic       unit_first;
	logic       unit_last;
	logic [4:0] unit_type;

	splitter_scoreboard sb = new();
	bit          idle_on   = 1'b1;
	bit          hold_done = 1'b0;
	int unsigned sent      = 0;

	annexb_start_code_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.unit_first   (unit_first),
		.unit_last    (unit_last),
		.unit_type    (unit_type)
	);

	always #(CLK_HALF) clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// byte values biased toward the ones that build start codes
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return ZERO_BYTE;
		if (r < 40)
			return ONE_BYTE;
		if (r < 45)
			return 8'h03;
		return 8'($urandom_range(255));
	endfunction

	// offer one stream byte and wait for its transfer
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_stream_byte(b);
		sent++;
	endtask

	// result side checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_payload_byte(payload_byte, unit_first, unit_last, unit_type);
	end

	// receiver: random stalls, plus one long hold-off to back up the input
	initial begin
		int unsigned stall;
		wait (arst_n);
		forever begin
			if (!hold_done && sb.checked >= 60) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = gap_len();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					out_ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned r;
		int unsigned n;
		int unsigned zeros;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i])
			send_byte(OPENING[i]);

		while (sent < OPENING_LEN + RANDOM_ITEMS) begin
			// every third stretch runs with no idling on either side
			idle_on = ((sent / 200) % 3) != 2;
			r = $urandom_range(99);
			if (r < 10) begin
				// noise, sometimes led by a broken start code
				if (r < 5) begin
					send_byte(ZERO_BYTE);
					send_byte(ONE_BYTE);
				end
				n = $urandom_range(12, 1);
				repeat (n) send_byte(pick_byte());
			end else begin
				// start code of three or four bytes or a longer zero run
				r = $urandom_range(99);
				zeros = (r < 65) ? 2 : (r < 90) ? 3 : $urandom_range(7, 4);
				repeat (zeros) send_byte(ZERO_BYTE);
				send_byte(ONE_BYTE);
				// header then a mostly short body
				send_byte(8'($urandom_range(255)));
				n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
				repeat (n) send_byte(pick_byte());
			end
		end
		in_valid <= 1'b0;

		// drain what is still predicted, then watch for stray results
		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
